>>> rtl/adpcm4bd_pkg.sv
package adpcm4bd_pkg;

   // Block geometry
   localparam int BLOCK_SAMPLES_DEFAULT = 14;
   localparam int POS_WIDTH             = 3;

   // Predictor weight registers
   localparam int COEFF_COUNT     = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COEFF_WIDTH     = 32;
   localparam int WEIGHT_WIDTH    = 16;

   // Arithmetic
   localparam int SAMPLE_WIDTH = 16;
   localparam int PROD_WIDTH   = 32;
   localparam int ACC_WIDTH    = 34;
   localparam int FRAC_BITS    = 11;
   localparam int HALF_ONE     = 'h400;
   localparam int SAT_LOW      = -32768;
   localparam int SAT_HIGH     = 32767;

   // Operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   typedef struct packed {
      logic                            op;
      logic [7:0]                      stream_byte;
      logic                            load_history;
      logic signed [SAMPLE_WIDTH-1:0]  start_recent;
      logic signed [SAMPLE_WIDTH-1:0]  start_older;
      logic                            final_byte;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0]  sample_value;
      logic                            run_last;
      logic                            buffer_end;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic start;       // start of buffer accepted
      logic header;      // header byte accepted
      logic data;        // data byte accepted
      logic mul;         // form products and scaled nibble
      logic nib_low;     // low nibble in the current multiply
      logic fire;        // commit sample to output and history
      logic run_last;
      logic buffer_end;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/adpcm4bd_ctrl.sv
module adpcm4bd_ctrl #(
   parameter int BLOCK_SAMPLES = adpcm4bd_pkg::BLOCK_SAMPLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_op,
   input  logic                        req_final,
   output logic                        req_stall,
   input  adpcm4bd_pkg::dp_status_type status,
   output adpcm4bd_pkg::dp_cmd_type    cmd
);

   localparam int DATA_BYTES = (BLOCK_SAMPLES + 1) / 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL_HI = 5'b00010,
      ST_ADD_HI = 5'b00100,
      ST_MUL_LO = 5'b01000,
      ST_ADD_LO = 5'b10000
   } state_type;

   state_type                                state_ff, state_in;
   logic [adpcm4bd_pkg::POS_WIDTH-1:0]       pos_ff, pos_in;
   logic                                     final_ff, final_in;
   logic                                     accept;
   logic                                     is_byte;
   logic                                     is_add;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign is_byte   = accept && (req_op == adpcm4bd_pkg::OP_BYTE);
   assign is_add    = (state_ff == ST_ADD_HI) || (state_ff == ST_ADD_LO);

   always_comb begin
      cmd.start      = accept && (req_op == adpcm4bd_pkg::OP_START);
      cmd.header     = is_byte && (pos_ff == '0);
      cmd.data       = is_byte && (pos_ff != '0);
      cmd.mul        = (state_ff == ST_MUL_HI) || (state_ff == ST_MUL_LO);
      cmd.nib_low    = (state_ff == ST_MUL_LO);
      cmd.fire       = is_add && status.out_free;
      cmd.run_last   = (state_ff == ST_ADD_LO);
      cmd.buffer_end = (state_ff == ST_ADD_LO) && final_ff;
   end

   always_comb begin
      pos_in   = pos_ff;
      final_in = final_ff;
      if (cmd.start) begin
         pos_in = '0;
      end else if (cmd.header) begin
         pos_in = req_final ? '0 : adpcm4bd_pkg::POS_WIDTH'(1);
      end else if (cmd.data) begin
         final_in = req_final;
         if (req_final || (pos_ff >= adpcm4bd_pkg::POS_WIDTH'(DATA_BYTES))) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + adpcm4bd_pkg::POS_WIDTH'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.data) state_in = ST_MUL_HI;
         end
         ST_MUL_HI: state_in = ST_ADD_HI;
         ST_ADD_HI: begin
            if (status.out_free) state_in = ST_MUL_LO;
         end
         ST_MUL_LO: state_in = ST_ADD_LO;
         ST_ADD_LO: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         final_ff <= final_in;
      end
   end

endmodule

>>> rtl/adpcm4bd_datapath.sv
module adpcm4bd_datapath (
   input  logic                                         clock,
   input  logic                                         reset,
   input  adpcm4bd_pkg::req_word_type                   req_word,
   input  logic                                         csr_write,
   input  logic [adpcm4bd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [adpcm4bd_pkg::COEFF_WIDTH-1:0]         csr_data,
   input  adpcm4bd_pkg::dp_cmd_type                     cmd,
   output adpcm4bd_pkg::dp_status_type                  status,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output adpcm4bd_pkg::rsp_word_type                   rsp_word
);

   localparam int ACC = adpcm4bd_pkg::ACC_WIDTH;
   localparam int SW  = adpcm4bd_pkg::SAMPLE_WIDTH;
   localparam int WW  = adpcm4bd_pkg::WEIGHT_WIDTH;
   localparam int PW  = adpcm4bd_pkg::PROD_WIDTH;

   localparam logic signed [ACC-1:0] ACC_HALF = ACC'(adpcm4bd_pkg::HALF_ONE);
   localparam logic signed [ACC-1:0] ACC_LOW  = ACC'(adpcm4bd_pkg::SAT_LOW);
   localparam logic signed [ACC-1:0] ACC_HIGH = ACC'(adpcm4bd_pkg::SAT_HIGH);

   logic [adpcm4bd_pkg::COEFF_WIDTH-1:0] coeff_ff [adpcm4bd_pkg::COEFF_COUNT];

   logic [3:0]                shift_ff;
   logic [2:0]                pred_ff;
   logic [7:0]                byte_ff;
   logic signed [SW-1:0]      recent_ff, older_ff;
   logic signed [PW-1:0]      p_recent_ff, p_recent_in;
   logic signed [PW-1:0]      p_older_ff, p_older_in;
   logic signed [ACC-1:0]     diff_ff, diff_in;
   logic                      rsp_valid_ff;
   adpcm4bd_pkg::rsp_word_type rsp_word_ff;

   logic [adpcm4bd_pkg::COEFF_WIDTH-1:0] pair;
   logic signed [WW-1:0]      w_recent, w_older;
   logic [3:0]                nib;
   logic signed [ACC-1:0]     nib_ext;
   logic signed [ACC-1:0]     sum, scaled;
   logic signed [SW-1:0]      sample;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

   // Multiply stage
   always_comb begin
      pair        = coeff_ff[pred_ff];
      w_recent    = $signed(pair[WW-1:0]);
      w_older     = $signed(pair[2*WW-1:WW]);
      p_recent_in = w_recent * recent_ff;
      p_older_in  = w_older * older_ff;
      nib         = cmd.nib_low ? byte_ff[3:0] : byte_ff[7:4];
      nib_ext     = ACC'($signed(nib));
      diff_in     = (nib_ext <<< shift_ff) <<< adpcm4bd_pkg::FRAC_BITS;
   end

   // Accumulate stage: add half, floor shift, then clamp to 16 bits
   always_comb begin
      sum    = ACC'(p_recent_ff) + ACC'(p_older_ff) + diff_ff + ACC_HALF;
      scaled = sum >>> adpcm4bd_pkg::FRAC_BITS;
      if (scaled < ACC_LOW) begin
         sample = SW'(ACC_LOW);
      end else if (scaled > ACC_HIGH) begin
         sample = SW'(ACC_HIGH);
      end else begin
         sample = scaled[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < adpcm4bd_pkg::COEFF_COUNT; i++) coeff_ff[i] <= '0;
         shift_ff  <= '0;
         pred_ff   <= '0;
         recent_ff <= '0;
         older_ff  <= '0;
      end else begin
         if (csr_write) coeff_ff[csr_index] <= csr_data;
         if (cmd.header) begin
            shift_ff <= req_word.stream_byte[3:0];
            pred_ff  <= req_word.stream_byte[6:4];
         end
         if (cmd.data) byte_ff <= req_word.stream_byte;
         if (cmd.mul) begin
            p_recent_ff <= p_recent_in;
            p_older_ff  <= p_older_in;
            diff_ff     <= diff_in;
         end
         if (cmd.start && req_word.load_history) begin
            recent_ff <= req_word.start_recent;
            older_ff  <= req_word.start_older;
         end else if (cmd.fire) begin
            recent_ff <= sample;
            older_ff  <= recent_ff;
         end
         if (cmd.fire) begin
            rsp_word_ff.sample_value <= sample;
            rsp_word_ff.run_last     <= cmd.run_last;
            rsp_word_ff.buffer_end   <= cmd.buffer_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

>>> rtl/adpcm_4bit_block_decoder.sv
// 4-bit ADPCM block decoder. Each request word is a buffer start (optionally
// loading the two history samples) or one stream byte; a block is a header
// byte then (BLOCK_SAMPLES+1)/2 data bytes, and each data byte returns two
// 16-bit samples, high nibble first. A start or header word is taken while
// idle and returns nothing. A data byte keeps the decoder busy after its
// accept while each sample passes a multiply step in the two 16x16 weight
// multipliers and a step in the 34-bit accumulate, round and clamp;
// the second sample needs the first in the history, so the samples go
// through that shared unit in turn. A stalled response holds the accumulate
// step until the output register frees. Weight registers are written
// through the csr port; the user must write them only while the decoder is
// idle, as the block does not enforce this; csr_ready is always high.
module adpcm_4bit_block_decoder #(
   parameter int BLOCK_SAMPLES = adpcm4bd_pkg::BLOCK_SAMPLES_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  adpcm4bd_pkg::req_word_type                req_word,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output adpcm4bd_pkg::rsp_word_type                rsp_word,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [adpcm4bd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [adpcm4bd_pkg::COEFF_WIDTH-1:0]      csr_data
);

   adpcm4bd_pkg::dp_cmd_type    cmd;
   adpcm4bd_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   adpcm4bd_ctrl #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_word.op),
      .req_final (req_word.final_byte),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   adpcm4bd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
